// ===== design/wcp_pkg.sv =====
// Package for the window co-occurrence pair emitter: shared constants and codes.
// Used by every module of the block; it depends on nothing else.
package wcp_pkg;

    // Default sizes. The top level takes these as its parameter defaults.
    localparam int MAX_WINDOW  = 16;
    localparam int ID_BITS     = 24;
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OBEY_BOUNDS = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] WINDOW_SIZE_RST = 5'd5;
    localparam logic                     OBEY_BOUNDS_RST = 1'b1;

    // Input item kinds (tuser)
    localparam logic CMD_WORD     = 1'b0;
    localparam logic CMD_BOUNDARY = 1'b1;

endpackage

// ===== design/window_cooccurrence_pair_emitter_top.sv =====
// Top level of the window co-occurrence pair emitter: front end, job queue, back end.
// Depends on wcp_pkg, wcp_front, wcp_queue and wcp_back.
//
//  channel  | direction | beat carries
//  ---------+-----------+----------------------------------------------
//  s_*      | in        | tuser: cmd; tdata: word_id (signed), zero pad
//  m_*      | out       | tdata: row_id, col_id; tlast: last_of_run
//  cfg_*    | in        | cfg_index: register, cfg_data: value
//
// When a word beat is taken, the front end shifts the window and, if the word yields
// any pair, hands the back end a job holding the new id, a copy of the older entries
// and a mask of the valid ones. The back end loads a job while idle and then emits
// two pairs per valid older entry; it takes no new job until the last pair of the
// current one is registered. The back end has a single pair path.
// s_tready drops only when the job queue is full.
// Reset (async, rst_n low) fills the window with -1 and loads window_size = 5,
// with boundary clearing enabled; no clearing pass follows.
module window_cooccurrence_pair_emitter_top #(
    parameter int MAX_WINDOW  = wcp_pkg::MAX_WINDOW,
    parameter int ID_BITS     = wcp_pkg::ID_BITS,
    parameter int QUEUE_DEPTH = wcp_pkg::QUEUE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wcp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wcp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((ID_BITS+1+7)/8)*8-1:0]          s_tdata,  // word_id, then zero pad
    input  logic                                   s_tuser,  // cmd
    // output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*ID_BITS+7)/8)*8-1:0]          m_tdata,  // row_id, col_id, then zero pad
    output logic                                   m_tlast   // last_of_run
);

    localparam int JOB_BITS      = ID_BITS * MAX_WINDOW + MAX_WINDOW - 1;
    localparam int OUT_DATA_BITS = ((2 * ID_BITS + 7) / 8) * 8;

    logic                front_valid;
    logic                front_ready;
    logic [JOB_BITS-1:0] front_data;
    logic                back_valid;
    logic                back_ready;
    logic [JOB_BITS-1:0] back_data;
    logic [ID_BITS-1:0]  row_id;
    logic [ID_BITS-1:0]  col_id;

    // Accept items, keep the window, build jobs
    wcp_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .ID_BITS    (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_word_id (s_tdata[ID_BITS:0]),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job_data   (front_data)
    );

    // Decouple the two ends
    wcp_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_data),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_data)
    );

    // Emit pairs oldest entry first, (new, old) then (old, new)
    wcp_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job_data  (back_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (row_id),
        .out_col   (col_id),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_DATA_BITS'({col_id, row_id});

endmodule

// ===== design/wcp_front.sv =====
// Front end of the pair emitter: config registers, window shift register and job build.
// Depends on wcp_pkg. Pushes one job per word that yields at least one pair.
module wcp_front #(
    parameter int MAX_WINDOW = wcp_pkg::MAX_WINDOW,
    parameter int ID_BITS    = wcp_pkg::ID_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wcp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wcp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    // input item
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_cmd,
    input  logic [ID_BITS:0]                       in_word_id,
    // job out: {mask, entries, new id}
    output logic                                   job_valid,
    input  logic                                   job_ready,
    output logic [ID_BITS*MAX_WINDOW+MAX_WINDOW-2:0] job_data
);

    localparam int OLD_SLOTS = MAX_WINDOW - 1;
    localparam int WS_BITS   = $clog2(MAX_WINDOW + 1);

    logic [wcp_pkg::CFG_DATA_BITS-1:0] win_size_reg;
    logic                              obey_reg;
    logic [ID_BITS:0]                  win_reg [OLD_SLOTS];

    logic [WS_BITS-1:0]          ws_eff;
    logic [OLD_SLOTS-1:0]        mask;
    logic [ID_BITS*OLD_SLOTS-1:0] ents;
    logic                        accept;
    logic                        is_word;

    assign cfg_ready = 1'b1;
    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign is_word   = (in_cmd == wcp_pkg::CMD_WORD);

    // Clamp the window size to 2..MAX_WINDOW
    always_comb
    begin
        int wsv;
        wsv = int'(win_size_reg);
        if (wsv < 2)
            wsv = 2;
        if (wsv > MAX_WINDOW)
            wsv = MAX_WINDOW;
        ws_eff = WS_BITS'(wsv);
    end

    // After the shift, old slot k sits at window position k+1
    always_comb
    begin
        for (int k = 0; k < OLD_SLOTS; k++)
        begin
            mask[k] = ((k + 1) < int'(ws_eff)) && !win_reg[k][ID_BITS];
            ents[k*ID_BITS +: ID_BITS] = win_reg[k][ID_BITS-1:0];
        end
    end

    assign job_valid = in_valid && is_word && !in_word_id[ID_BITS] && (mask != '0);
    assign job_data  = {mask, ents, in_word_id[ID_BITS-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= wcp_pkg::WINDOW_SIZE_RST;
            obey_reg     <= wcp_pkg::OBEY_BOUNDS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wcp_pkg::CFG_WINDOW_SIZE: win_size_reg <= cfg_data;
                wcp_pkg::CFG_OBEY_BOUNDS: obey_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < OLD_SLOTS; k++)
                win_reg[k] <= '1;
        end
        else if (accept)
        begin
            if (is_word)
            begin
                win_reg[0] <= in_word_id;
                for (int k = 1; k < OLD_SLOTS; k++)
                    win_reg[k] <= win_reg[k-1];
            end
            else if (obey_reg)
            begin
                for (int k = 0; k < OLD_SLOTS; k++)
                    win_reg[k] <= '1;
            end
        end
    end

endmodule

// ===== design/wcp_queue.sv =====
// Short job queue between the front and back ends of the pair emitter.
// Depends on wcp_pkg for its default depth.
module wcp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wcp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push;
    logic                pop;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/wcp_back.sv =====
// Back end of the pair emitter: walks one job, one pair a beat, into an output register.
// Depends on wcp_pkg for parameter defaults.
module wcp_back #(
    parameter int MAX_WINDOW = wcp_pkg::MAX_WINDOW,
    parameter int ID_BITS    = wcp_pkg::ID_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     job_valid,
    output logic                                     job_ready,
    input  logic [ID_BITS*MAX_WINDOW+MAX_WINDOW-2:0] job_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [ID_BITS-1:0]                       out_row,
    output logic [ID_BITS-1:0]                       out_col,
    output logic                                     out_last
);

    localparam int OLD_SLOTS = MAX_WINDOW - 1;
    localparam int SEL_BITS  = (OLD_SLOTS > 1) ? $clog2(OLD_SLOTS) : 1;

    logic                         busy_reg;
    logic                         phase_reg;
    logic [ID_BITS-1:0]           id_reg;
    logic [ID_BITS*OLD_SLOTS-1:0] ents_reg;
    logic [OLD_SLOTS-1:0]         mask_reg;
    logic                         out_valid_reg;
    logic [ID_BITS-1:0]           row_reg;
    logic [ID_BITS-1:0]           col_reg;
    logic                         last_reg;

    logic [SEL_BITS-1:0]  sel;
    logic [OLD_SLOTS-1:0] mask_next;
    logic [ID_BITS-1:0]   ent;
    logic                 advance;

    // Oldest valid entry is the highest set mask bit
    always_comb
    begin
        sel = '0;
        for (int k = 0; k < OLD_SLOTS; k++)
        begin
            if (mask_reg[k])
                sel = SEL_BITS'(k);
        end
        for (int k = 0; k < OLD_SLOTS; k++)
            mask_next[k] = mask_reg[k] && (SEL_BITS'(k) != sel);
    end

    assign ent       = ents_reg[sel*ID_BITS +: ID_BITS];
    assign advance   = !out_valid_reg || out_ready;
    assign job_ready = !busy_reg;

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            if (!busy_reg)
            begin
                // load the next job
                if (job_valid)
                begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    mask_reg  <= job_data[ID_BITS*MAX_WINDOW +: OLD_SLOTS];
                end
            end
            else if (advance)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    mask_reg <= mask_next;
                    if (mask_next == '0)
                        busy_reg <= 1'b0;
                end
            end
            if (advance)
                out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
        begin
            id_reg   <= job_data[ID_BITS-1:0];
            ents_reg <= job_data[ID_BITS +: ID_BITS*OLD_SLOTS];
        end
        if (busy_reg && advance)
        begin
            row_reg  <= phase_reg ? ent : id_reg;
            col_reg  <= phase_reg ? id_reg : ent;
            last_reg <= phase_reg && (mask_next == '0);
        end
    end

endmodule

// ===== test/tb_window_cooccurrence_pair_emitter_top.sv =====
// Testbench for window_cooccurrence_pair_emitter_top: directed and random word/boundary beats,
// checked pair by pair against an in-bench window predictor. Needs wcp_pkg and the design RTL.
`timescale 1ns / 100ps

module tb_window_cooccurrence_pair_emitter_top;

    localparam int ID_W          = wcp_pkg::ID_BITS;
    localparam int WIN_DEPTH     = wcp_pkg::MAX_WINDOW;
    localparam int IDX_W         = wcp_pkg::CFG_INDEX_BITS;
    localparam int CFG_W         = wcp_pkg::CFG_DATA_BITS;
    localparam int S_DATA_W      = ((ID_W + 1 + 7) / 8) * 8;
    localparam int M_DATA_W      = ((2 * ID_W + 7) / 8) * 8;
    // The worst back-end job yields 2*(16-1) pairs and the job queue holds two more:
    // leave a wide margin before touching registers or ending the run.
    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_REPORTS   = 10;

    typedef logic signed [ID_W:0] word_id_t;

    // One stream beat waiting to go out, plus its pacing.
    typedef struct {
        logic        cmd;
        word_id_t    word_id;
        int unsigned gap;          // idle cycles after this beat
        bit          drain_first;  // hold until every pending pair has arrived
    } stream_item_t;

    typedef struct packed {
        logic [ID_W-1:0] row_id;
        logic [ID_W-1:0] col_id;
        logic            last;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // word_id, then zero pad
    logic                s_tuser = 1'b0; // cmd

    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [M_DATA_W-1:0] m_tdata;        // row_id, col_id, then zero pad
    logic                m_tlast;        // last_of_run

    // Predictor state: its own window and register copies.
    word_id_t   recent_ids [WIN_DEPTH];
    logic [4:0] window_size_q = wcp_pkg::WINDOW_SIZE_RST;
    logic       obey_bounds_q = wcp_pkg::OBEY_BOUNDS_RST;

    stream_item_t stream_items[$];
    pair_t        expected_pairs[$];

    // Pacing controls, set per phase.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    int unsigned beats_sent = 0;
    int unsigned boundaries_sent = 0;
    int unsigned pairs_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned error_count = 0;

    window_cooccurrence_pair_emitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Shift one accepted word beat into the predicted window, or apply a boundary, and queue the pairs it
    // yields: newest id against each older valid entry, oldest first, both orders.
    function automatic void shift_and_predict_pairs(input logic cmd, input word_id_t id);
        pair_t    run_pairs[$];
        word_id_t older;
        int       span;
        if (cmd == wcp_pkg::CMD_BOUNDARY)
        begin
            // Boundary clears only when bounds are obeyed; never yields pairs.
            if (obey_bounds_q)
                foreach (recent_ids[i])
                    recent_ids[i] = -1;
            return;
        end
        for (int i = WIN_DEPTH - 1; i > 0; i--)
            recent_ids[i] = recent_ids[i - 1];
        recent_ids[0] = id;
        // Saturate the programmed size into 2..depth.
        span = int'(window_size_q);
        if (span < 2)
            span = 2;
        if (span > WIN_DEPTH)
            span = WIN_DEPTH;
        // Any negative id acts as out of vocabulary on either side of a pair.
        if (id >= 0)
        begin
            for (int i = span - 1; i >= 1; i--)
            begin
                older = recent_ids[i];
                if (older >= 0)
                begin
                    run_pairs.insert(run_pairs.size(),
                                     '{row_id: id[ID_W-1:0], col_id: older[ID_W-1:0],
                                       last: 1'b0});
                    run_pairs.insert(run_pairs.size(),
                                     '{row_id: older[ID_W-1:0], col_id: id[ID_W-1:0],
                                       last: 1'b0});
                end
            end
        end
        if (run_pairs.size() > 0)
            run_pairs[run_pairs.size() - 1].last = 1'b1;
        foreach (run_pairs[i])
            expected_pairs.insert(expected_pairs.size(), run_pairs[i]);
    endfunction

    // Driver: present queued beats, predict on acceptance, insert the drawn gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= wcp_pkg::CMD_WORD;
            gap_left <= 0;
            foreach (recent_ids[i])
                recent_ids[i] = -1;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                shift_and_predict_pairs(s_tuser, word_id_t'(s_tdata[ID_W:0]));
                beats_sent++;
                if (s_tuser == wcp_pkg::CMD_BOUNDARY)
                    boundaries_sent++;
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the beat until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (stream_items.size() > 0 &&
                     (!stream_items[0].drain_first || expected_pairs.size() == 0))
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= stream_items[0].cmd;
                s_tdata  <= {{(S_DATA_W - ID_W - 1){1'b0}}, stream_items[0].word_id};
                gap_left <= stream_items[0].gap;
                void'(stream_items.pop_front());
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted pair against the oldest expectation, then
    // draw the stall before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        pair_t       want;
        pair_t       got;
        int unsigned stall;
        if (!rst_n)
        begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            got = '{row_id: m_tdata[ID_W-1:0], col_id: m_tdata[2*ID_W-1:ID_W],
                    last: m_tlast};
            if (expected_pairs.size() == 0)
            begin
                if (error_count < MAX_REPORTS)
                    $display("[%0t] unexpected pair row=%0d col=%0d last=%0b",
                             $realtime, got.row_id, got.col_id, got.last);
                error_count++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (got != want)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("[%0t] mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 $realtime, want.row_id, want.col_id, want.last,
                                 got.row_id, got.col_id, got.last);
                    error_count++;
                end
                pairs_checked++;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            m_tready   <= (stall == 0);
            stall_left <= stall;
        end
        else if (!m_tready)
        begin
            if (stall_left > 1)
                stall_left <= stall_left - 1;
            else
            begin
                stall_left <= 0;
                m_tready   <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog: no beat moved for %0d cycles, %0d pairs still expected",
                     idle_cycles, expected_pairs.size());
            $display("tb_window_cooccurrence_pair_emitter_top: FAIL");
            $finish;
        end
    end

    // Queue one stream beat; the gap follows the current pacing mode.
    task automatic queue_beat(input logic cmd, input word_id_t id, input bit drain = 1'b0);
        stream_item_t item;
        item.cmd         = cmd;
        item.word_id     = id;
        item.gap         = tx_steady ? 0 : $urandom_range(0, 11);
        item.drain_first = drain;
        stream_items.insert(stream_items.size(), item);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == wcp_pkg::CFG_WINDOW_SIZE)
            window_size_q = value;
        else
            obey_bounds_q = value[0];
        reg_writes++;
    endtask

    // Wait until every beat is out and every pair has come, then let the
    // whole block settle.
    task automatic wait_for_idle();
        while (stream_items.size() != 0 || s_tvalid || expected_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly small ids so pairs repeat, with full-range, -1 and other negatives.
    function automatic word_id_t random_word_id();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return word_id_t'($urandom_range(0, 23));
            5, 6:          return {1'b0, 24'($urandom)};
            7:             return -1;
            8:             return {1'b1, 24'($urandom)};
            default:       return word_id_t'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [CFG_W-1:0] ws_plan [6];
        logic [CFG_W-1:0] obey_plan [6];
        int drain_at;
        ws_plan   = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd9, 5'd0};
        obey_plan = '{5'd1, 5'd0, 5'b10101, 5'b11110, 5'd1, 5'd0};

        wait (rst_n);
        @(posedge clk);

        // Directed, reset values (window 5, bounds obeyed): id extremes,
        // unknown and other negative ids, boundary clearing, no-pair words.
        queue_beat(wcp_pkg::CMD_WORD, 0);
        queue_beat(wcp_pkg::CMD_WORD, 24'hFFFFFF);
        queue_beat(wcp_pkg::CMD_WORD, -1);
        queue_beat(wcp_pkg::CMD_WORD, 24'hAAAAAA);
        queue_beat(wcp_pkg::CMD_WORD, -2);
        queue_beat(wcp_pkg::CMD_WORD, {1'b1, 24'h000000});
        queue_beat(wcp_pkg::CMD_WORD, 24'h555555);
        queue_beat(wcp_pkg::CMD_BOUNDARY, 24'h123456);
        queue_beat(wcp_pkg::CMD_WORD, 5);
        queue_beat(wcp_pkg::CMD_WORD, 5);
        queue_beat(wcp_pkg::CMD_BOUNDARY, -1, 1'b1);
        queue_beat(wcp_pkg::CMD_WORD, 3);
        wait_for_idle();

        // Directed, window below range (saturates to 2) and bounds ignored:
        // the boundary must leave the window alone.
        write_reg(wcp_pkg::CFG_WINDOW_SIZE, 5'd0);
        write_reg(wcp_pkg::CFG_OBEY_BOUNDS, 5'd0);
        queue_beat(wcp_pkg::CMD_WORD, 9);
        queue_beat(wcp_pkg::CMD_WORD, 10);
        queue_beat(wcp_pkg::CMD_BOUNDARY, 0);
        queue_beat(wcp_pkg::CMD_WORD, 11);
        queue_beat(wcp_pkg::CMD_WORD, -1);
        queue_beat(wcp_pkg::CMD_WORD, 12);
        wait_for_idle();

        // Random phases. The window is never cleared between them, so growing
        // the size exposes entries shifted in under a smaller one.
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                ws_plan[p]   = 5'($urandom);
                obey_plan[p] = 5'($urandom);
            end
            write_reg(wcp_pkg::CFG_WINDOW_SIZE, ws_plan[p]);
            write_reg(wcp_pkg::CFG_OBEY_BOUNDS, obey_plan[p]);
            tx_steady = ($urandom_range(0, 2) == 0);
            rx_steady = ($urandom_range(0, 2) == 0);
            drain_at  = $urandom_range(3, 11);
            for (int n = 0; n < 14; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    queue_beat(wcp_pkg::CMD_WORD, random_word_id(), n == drain_at);
                else
                    queue_beat(wcp_pkg::CMD_BOUNDARY, word_id_t'($urandom), n == drain_at);
            end
            wait_for_idle();
        end

        rx_steady = 1'b0;
        if (expected_pairs.size() != 0)
        begin
            $display("%0d expected pairs never arrived", expected_pairs.size());
            error_count += expected_pairs.size();
        end

        $display("run covered %0d stream beats (%0d boundaries) over 8 register settings,",
                 beats_sent, boundaries_sent);
        $display("%0d pairs checked, %0d register writes, %0d errors",
                 pairs_checked, reg_writes, error_count);
        if (error_count == 0)
            $display("tb_window_cooccurrence_pair_emitter_top: PASS");
        else
            $display("tb_window_cooccurrence_pair_emitter_top: FAIL");
        $finish;
    end

endmodule
